/* rtl/core/jcs_pkg.sv */
// Shared types and constants for the jet cut and leading-jet selector.
// No dependencies; imported by every module in rtl/core.
`default_nettype none

package jcs_pkg;

    // Number of leading kept jets held per event
    localparam int LEADING_KEPT = 4;
    // Ranked results emitted per closed event
    localparam int NUM_RANKS    = 4;
    localparam int RANK_W       = 2;
    // Event records buffered between front and back
    localparam int QUEUE_DEPTH  = 2;

    localparam int KEPT_W = 8;
    localparam logic [KEPT_W-1:0] KEPT_MAX = '1;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] REG_MIN_JETS        = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MIN_ET          = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_ABS_ETA     = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_EM_FRACTION = 2'd3;

    localparam int IN_DATA_W  = 56;
    localparam int OUT_DATA_W = 64;

    typedef struct packed {
        logic [7:0]  min_jets;
        logic [15:0] min_et;
        logic [8:0]  max_abs_eta;
        logic [10:0] max_em_fraction;
    } cfg_t;

    typedef struct packed {
        logic [15:0]       energy;
        logic [15:0]       et;
        logic signed [9:0] eta;
        logic [10:0]       em_fraction;
    } jet_t;

    typedef struct packed {
        logic valid;
        jet_t jet;
    } slot_t;

    typedef struct packed {
        slot_t [LEADING_KEPT-1:0] slots;
        logic [KEPT_W-1:0]        kept_count;
        logic                     pass;
    } event_rec_t;

    typedef struct packed {
        logic not_full;
        logic not_empty;
    } q_stat_t;

endpackage

`default_nettype wire

/* rtl/core/jet_cut_top4_selector.sv */
// Top level of the jet cut and leading-four selector: config registers and the
// front end, event queue and back end. Depends on jcs_pkg, jcs_front, jcs_queue, jcs_back.
`default_nettype none

// The block takes one jet item per clock on the s_ stream, with no gap needed
// between items or between events. Each jet is checked against min_et,
// max_abs_eta and max_em_fraction; kept jets are counted (saturating at 255)
// and the four highest-energy ones are held sorted, earlier jet first on a tie.
// The item carrying tlast closes the event (also with tuser low, adding no jet);
// its record goes into a two-entry event queue and the back end then sends four
// results, rank 0 to 3, on the m_ stream, one per clock while m_tready is high,
// tlast on rank 3. The record passes through the queue into the output register,
// which raises m_tvalid for the first result once earlier events are sent.
// Output runs at one result per clock while m_tready is high, so sustained input
// rate is one item per clock as long as events average at least four items;
// s_tready drops only when both queue entries hold events still being sent. A
// slot is valid only if the event passed (kept count >= min_jets) and a jet is
// held at that rank; invalid slots carry zero jet fields.
// Config registers are written on cfg_we; write them only while idle.

module jet_cut_top4_selector (
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    // config write port
    input  wire logic                                 cfg_we,
    input  wire logic [jcs_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  wire logic [jcs_pkg::CFG_DATA_W-1:0]       cfg_data,
    // jet input stream
    input  wire logic                                 s_tvalid,
    output logic                                      s_tready,
    // tdata: jet_energy[15:0], jet_et[31:16], jet_eta[41:32], jet_em_fraction[52:42], zero pad
    input  wire logic [jcs_pkg::IN_DATA_W-1:0]        s_tdata,
    // tuser: jet_present
    input  wire logic                                 s_tuser,
    input  wire logic                                 s_tlast,
    // ranked result stream
    output logic                                      m_tvalid,
    input  wire logic                                 m_tready,
    // tdata: rank[1:0], out_energy[17:2], out_et[33:18], out_eta[43:34],
    //        out_em_fraction[54:44], event_pass[55], kept_count[63:56]
    output logic [jcs_pkg::OUT_DATA_W-1:0]            m_tdata,
    // tuser: slot_valid
    output logic                                      m_tuser,
    output logic                                      m_tlast
);
    import jcs_pkg::*;

    cfg_t       cfg_reg;
    q_stat_t    q_stat;
    logic       q_push;
    logic       q_pop;
    event_rec_t q_push_rec;
    event_rec_t q_head_rec;

    // config registers, reset to the documented defaults
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.min_jets        <= 8'd4;
            cfg_reg.min_et          <= 16'd80;
            cfg_reg.max_abs_eta     <= 9'd250;
            cfg_reg.max_em_fraction <= 11'd1024;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_MIN_JETS:        cfg_reg.min_jets        <= cfg_data[7:0];
                REG_MIN_ET:          cfg_reg.min_et          <= cfg_data[15:0];
                REG_MAX_ABS_ETA:     cfg_reg.max_abs_eta     <= cfg_data[8:0];
                REG_MAX_EM_FRACTION: cfg_reg.max_em_fraction <= cfg_data[10:0];
                default:             cfg_reg                 <= cfg_reg;
            endcase
        end
    end

    // cuts and leading-jet insert, one item per clock while s_tready is high
    jcs_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg_reg),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .s_tlast    (s_tlast),
        .q_stat     (q_stat),
        .q_push     (q_push),
        .q_push_rec (q_push_rec)
    );

    // closed events waiting to be sent
    jcs_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (q_push),
        .push_rec (q_push_rec),
        .pop      (q_pop),
        .head_rec (q_head_rec),
        .stat     (q_stat)
    );

    // four ranked results per event, one per clock while m_tready is high
    jcs_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .q_stat   (q_stat),
        .head_rec (q_head_rec),
        .q_pop    (q_pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

endmodule

`default_nettype wire

/* rtl/core/jcs_front.sv */
// Front end: applies the jet cuts and keeps the leading jets of the open event.
// Depends on jcs_pkg; pushes one event record per closed event into jcs_queue.
`default_nettype none

module jcs_front (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire jcs_pkg::cfg_t                       cfg,
    input  wire logic                                s_tvalid,
    output logic                                     s_tready,
    // tdata: jet_energy[15:0], jet_et[31:16], jet_eta[41:32], jet_em_fraction[52:42], zero pad
    input  wire logic [jcs_pkg::IN_DATA_W-1:0]       s_tdata,
    // tuser: jet_present
    input  wire logic                                s_tuser,
    input  wire logic                                s_tlast,
    input  wire jcs_pkg::q_stat_t                    q_stat,
    output logic                                     q_push,
    output jcs_pkg::event_rec_t                      q_push_rec
);
    import jcs_pkg::*;

    slot_t [LEADING_KEPT-1:0] slots_reg;
    slot_t [LEADING_KEPT-1:0] slots_next;
    logic [KEPT_W-1:0]        kept_reg;
    logic [KEPT_W-1:0]        kept_next;

    jet_t                     new_jet;
    logic [9:0]               abs_eta;
    logic                     keep;
    logic                     accept;
    logic [LEADING_KEPT-1:0]  gt;

    assign new_jet.energy      = s_tdata[15:0];
    assign new_jet.et          = s_tdata[31:16];
    assign new_jet.eta         = s_tdata[41:32];
    assign new_jet.em_fraction = s_tdata[52:42];

    assign s_tready = q_stat.not_full;
    assign accept   = s_tvalid && s_tready;

    always_comb
    begin
        // -512 maps to 512, still fits 10 unsigned bits
        abs_eta = new_jet.eta[9] ? (~new_jet.eta + 10'd1) : new_jet.eta;
        keep = s_tuser
            && (new_jet.et >= cfg.min_et)
            && (abs_eta <= {1'b0, cfg.max_abs_eta})
            && (new_jet.em_fraction <= cfg.max_em_fraction);

        // slots are sorted and valid as a prefix, so gt is monotone
        for (int i = 0; i < LEADING_KEPT; i++)
        begin
            gt[i] = !slots_reg[i].valid || (new_jet.energy > slots_reg[i].jet.energy);
        end

        slots_next[0] = slots_reg[0];
        if (keep && gt[0])
        begin
            slots_next[0].valid = 1'b1;
            slots_next[0].jet   = new_jet;
        end
        for (int i = 1; i < LEADING_KEPT; i++)
        begin
            slots_next[i] = slots_reg[i];
            if (keep && gt[i])
            begin
                if (gt[i-1])
                begin
                    slots_next[i] = slots_reg[i-1];
                end
                else
                begin
                    slots_next[i].valid = 1'b1;
                    slots_next[i].jet   = new_jet;
                end
            end
        end

        kept_next = (keep && (kept_reg != KEPT_MAX)) ? kept_reg + 1'b1 : kept_reg;
    end

    assign q_push                = accept && s_tlast;
    assign q_push_rec.slots      = slots_next;
    assign q_push_rec.kept_count = kept_next;
    assign q_push_rec.pass       = (kept_next >= cfg.min_jets);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slots_reg <= '0;
            kept_reg  <= '0;
        end
        else if (accept)
        begin
            if (s_tlast)
            begin
                slots_reg <= '0;
                kept_reg  <= '0;
            end
            else
            begin
                slots_reg <= slots_next;
                kept_reg  <= kept_next;
            end
        end
    end

endmodule

`default_nettype wire

/* rtl/core/jcs_queue.sv */
// Short queue of closed-event records between front and back end.
// Depends on jcs_pkg.
`default_nettype none

module jcs_queue (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 push,
    input  wire jcs_pkg::event_rec_t  push_rec,
    input  wire logic                 pop,
    output jcs_pkg::event_rec_t       head_rec,
    output jcs_pkg::q_stat_t          stat
);
    import jcs_pkg::*;

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(QUEUE_DEPTH);

    event_rec_t        entries_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg;
    logic [PTR_W-1:0]  wr_ptr_next;
    logic [PTR_W-1:0]  rd_ptr_reg;
    logic [PTR_W-1:0]  rd_ptr_next;
    logic [CNT_W-1:0]  count_reg;
    logic [CNT_W-1:0]  count_next;

    assign stat.not_full  = (count_reg != CNT_FULL);
    assign stat.not_empty = (count_reg != '0);
    assign head_rec       = entries_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? ((wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1) : wr_ptr_reg;
        rd_ptr_next = pop  ? ((rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1) : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entries_reg[wr_ptr_reg] <= push_rec;
        end
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_FULL)
        else $error("queue count above depth");

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> stat.not_full)
        else $error("push into full queue");

    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> stat.not_empty)
        else $error("pop from empty queue");

endmodule

`default_nettype wire

/* rtl/core/jcs_back.sv */
// Back end: walks the head event record rank by rank into the output register.
// Depends on jcs_pkg; reads and pops jcs_queue.
`default_nettype none

module jcs_back (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire jcs_pkg::q_stat_t                    q_stat,
    input  wire jcs_pkg::event_rec_t                 head_rec,
    output logic                                     q_pop,
    output logic                                     m_tvalid,
    input  wire logic                                m_tready,
    // tdata: rank[1:0], out_energy[17:2], out_et[33:18], out_eta[43:34],
    //        out_em_fraction[54:44], event_pass[55], kept_count[63:56]
    output logic [jcs_pkg::OUT_DATA_W-1:0]           m_tdata,
    // tuser: slot_valid
    output logic                                     m_tuser,
    output logic                                     m_tlast
);
    import jcs_pkg::*;

    localparam logic [RANK_W-1:0] RANK_LAST = RANK_W'(NUM_RANKS - 1);

    logic [RANK_W-1:0]     rank_reg;
    logic                  out_valid_reg;
    logic [OUT_DATA_W-1:0] out_data_reg;
    logic                  out_user_reg;
    logic                  out_last_reg;

    logic                  load;
    logic                  emit;
    slot_t                 sel;
    logic                  slot_ok;
    jet_t                  shown;
    logic [OUT_DATA_W-1:0] data_next;

    assign load  = !out_valid_reg || m_tready;
    assign emit  = load && q_stat.not_empty;
    assign q_pop = emit && (rank_reg == RANK_LAST);

    always_comb
    begin
        sel = '0;
        for (int k = 0; k < LEADING_KEPT; k++)
        begin
            if (RANK_W'(k) == rank_reg && k < NUM_RANKS)
            begin
                sel = head_rec.slots[k];
            end
        end
        slot_ok   = head_rec.pass && sel.valid;
        shown     = slot_ok ? sel.jet : '0;
        data_next = {head_rec.kept_count, head_rec.pass, shown.em_fraction,
                     shown.eta, shown.et, shown.energy, rank_reg};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rank_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else if (load)
        begin
            out_valid_reg <= q_stat.not_empty;
            if (emit)
            begin
                rank_reg <= (rank_reg == RANK_LAST) ? '0 : rank_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            out_data_reg <= data_next;
            out_user_reg <= slot_ok;
            out_last_reg <= (rank_reg == RANK_LAST);
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_user_reg;
    assign m_tlast  = out_last_reg;

    a_last_rank: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tlast) |-> (m_tdata[RANK_W-1:0] == RANK_LAST))
        else $error("tlast on a result that is not the last rank");

    a_rank_wrap: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |=> (rank_reg == '0))
        else $error("rank counter not back at zero after pop");

endmodule

`default_nettype wire
